// ===== rtl/tfd_pkg.sv =====
// Shared constants and types for the tilemap frame delta decoder.
`default_nettype none
package tfd_pkg;

    localparam int TILE_COUNT = 1024;
    localparam int ADDR_W     = $clog2(TILE_COUNT);
    localparam int POS_W      = 12;
    localparam int IDX_EXT_W  = 12;
    localparam logic [POS_W-1:0] POS_MAX = 12'hFFF;

    localparam logic [1:0] ST_PROGRESS    = 2'd0;
    localparam logic [1:0] ST_COMPLETE    = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ST_DROPPED     = 2'd3;

    localparam logic [3:0] MODE_PLAIN       = 4'd0;
    localparam logic [3:0] MODE_PLAIN_PIXEL = 4'd3;
    localparam logic [3:0] MODE_DERIVE      = 4'd4;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_req_t;

    typedef struct packed {
        logic       start;
        logic [7:0] value;
    } fill_req_t;

endpackage
`default_nettype wire

// ===== rtl/tfd_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module tfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/tfd_fill.sv =====
// Sweep engine that writes one value into every tile, after reset and on fill headers.
`default_nettype none
module tfd_fill (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire tfd_pkg::fill_req_t  fill_req,
    output logic                     busy,
    output tfd_pkg::wr_req_t         wr
);
    import tfd_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TILE_COUNT - 1);

    logic              busy_reg,  busy_next;
    logic [ADDR_W-1:0] addr_reg,  addr_next;
    logic [7:0]        value_reg, value_next;

    always_comb begin
        busy_next  = busy_reg;
        addr_next  = addr_reg;
        value_next = value_reg;
        if (busy_reg) begin
            addr_next = addr_reg + 1'b1;
            if (addr_reg == LAST_ADDR) begin
                busy_next = 1'b0;
            end
        end else if (fill_req.start) begin
            busy_next  = 1'b1;
            addr_next  = '0;
            value_next = fill_req.value;
        end
    end

    // Reset starts a clearing pass that writes zero into the whole store.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b1;
            addr_reg  <= '0;
            value_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            addr_reg  <= addr_next;
            value_reg <= value_next;
        end
    end

    assign busy    = busy_reg;
    assign wr.en   = busy_reg;
    assign wr.addr = addr_reg;
    assign wr.data = value_reg;
endmodule
`default_nettype wire

// ===== rtl/tfd_parser.sv =====
// Stream parser: header, count and patch word decoding with the frame state registers.
`default_nettype none
module tfd_parser (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               feed,
    input  wire logic [7:0]         stream_byte,
    output logic      [1:0]         status,
    output tfd_pkg::wr_req_t        wr,
    output tfd_pkg::fill_req_t      fill_req
);
    import tfd_pkg::*;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_COUNT  = 3'd1;
    localparam logic [2:0] PH_HI     = 3'd2;
    localparam logic [2:0] PH_LO     = 3'd3;

    logic [2:0]       phase_reg,   phase_next;
    logic             mode_reg,    mode_next;
    logic [POS_W-1:0] left_reg,    left_next;
    logic [POS_W-1:0] wpos_reg,    wpos_next;
    logic [7:0]       high_reg,    high_next;

    logic [15:0]      word;
    logic [10:0]      skip;
    logic [7:0]       patch_val;
    logic [POS_W:0]   pos_sum;
    logic [POS_W-1:0] pos_sat;
    logic [POS_W-1:0] count;
    logic [POS_W-1:0] left_dec;
    logic             in_store;

    always_comb begin
        word      = {high_reg, stream_byte};
        skip      = word[15:5];
        patch_val = word[4] ? 8'h80 : {4'h0, word[3:0]};
        pos_sum   = {1'b0, wpos_reg} + {2'b00, skip};
        pos_sat   = (pos_sum > {1'b0, POS_MAX}) ? POS_MAX : pos_sum[POS_W-1:0];
        in_store  = pos_sat < POS_W'(TILE_COUNT);
        count     = mode_reg ? {left_reg[3:0], stream_byte} : {4'h0, stream_byte};
        left_dec  = left_reg - 1'b1;

        phase_next = phase_reg;
        mode_next  = mode_reg;
        left_next  = left_reg;
        wpos_next  = wpos_reg;
        high_next  = high_reg;
        status     = ST_PROGRESS;
        wr         = '0;
        fill_req   = '0;

        case (phase_reg)
            PH_COUNT: begin
                left_next = count;
                wpos_next = '0;
                if (count == '0) begin
                    phase_next = PH_HEADER;
                    status     = ST_COMPLETE;
                end else begin
                    phase_next = PH_HI;
                end
            end
            PH_HI: begin
                high_next  = stream_byte;
                phase_next = PH_LO;
            end
            PH_LO: begin
                wr.en   = feed && in_store;
                wr.addr = pos_sat[ADDR_W-1:0];
                wr.data = patch_val;
                if (!in_store) begin
                    status = ST_DROPPED;
                end
                wpos_next = (pos_sat < POS_MAX) ? pos_sat + 1'b1 : pos_sat;
                left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next = PH_HEADER;
                    if (in_store) begin
                        status = ST_COMPLETE;
                    end
                end else begin
                    phase_next = PH_HI;
                end
            end
            default: begin
                // Unused phase codes behave as waiting for a header.
                phase_next     = PH_HEADER;
                wpos_next      = '0;
                fill_req.value = {4'h0, stream_byte[3:0]};
                if (stream_byte[7:4] == MODE_PLAIN) begin
                    fill_req.start = feed;
                    status         = ST_COMPLETE;
                end else if (stream_byte[7:4] == MODE_PLAIN_PIXEL) begin
                    fill_req.start = feed;
                    mode_next      = 1'b0;
                    left_next      = '0;
                    phase_next     = PH_COUNT;
                end else if (stream_byte[7:4] == MODE_DERIVE) begin
                    mode_next  = 1'b1;
                    left_next  = {8'h00, stream_byte[3:0]};
                    phase_next = PH_COUNT;
                end else begin
                    status = ST_UNSUPPORTED;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            mode_reg  <= 1'b0;
            left_reg  <= '0;
            wpos_reg  <= '0;
            high_reg  <= '0;
        end else if (feed) begin
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            left_reg  <= left_next;
            wpos_reg  <= wpos_next;
            high_reg  <= high_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/tilemap_frame_delta_decoder.sv =====
// Top level of the tilemap frame delta decoder: handshakes, tile store and result register.
//
// The input channel (s_) carries one word per item: with s_action low it feeds
// s_stream_byte into the frame decoder, with s_action high it reads the tile at
// s_read_index. Every item gives exactly one result word on the m_ channel:
// m_tile_value holds the tile for a read and zero for a feed, m_status reports
// progress, frame completion, an unsupported mode or a dropped patch write.
// An accepted item is held in a request register and resolved once the result
// register is free, and its result word is then loaded into the result register.
// The tile store is a single synchronous RAM; reads use its registered read port
// and patch writes go to its write port. A plain or plain-and-pixel header
// fills the store one tile per cycle, which keeps s_ready low until that sweep
// is done. After reset the same engine clears the store to zero, so s_ready
// stays low until the clearing pass is done. A stalled receiver holds the result
// register; one more item may be accepted and waits in the request register
// until the result is taken.
`default_nettype none
module tilemap_frame_delta_decoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_action,
    input  wire logic [7:0] s_stream_byte,
    input  wire logic [9:0] s_read_index,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic      [7:0] m_tile_value,
    output logic      [1:0] m_status
);
    import tfd_pkg::*;

    logic             req_valid_reg, req_valid_next;
    logic             req_action_reg;
    logic [7:0]       req_byte_reg;
    logic             req_inrange_reg;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_tile_reg;
    logic [1:0]       m_status_reg;

    logic             s_fire;
    logic             process;
    logic             feed;
    logic [IDX_EXT_W-1:0] idx_ext;
    logic [7:0]       rdata;
    logic [1:0]       parse_status;
    wr_req_t          parse_wr;
    wr_req_t          fill_wr;
    wr_req_t          ram_wr;
    fill_req_t        fill_req;
    logic             fill_busy;

    assign idx_ext = {{(IDX_EXT_W-10){1'b0}}, s_read_index};
    assign s_ready = !fill_busy && !req_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign process = req_valid_reg && (!m_valid_reg || m_ready);
    assign feed    = process && !req_action_reg;
    assign ram_wr  = fill_busy ? fill_wr : parse_wr;

    tfd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .feed        (feed),
        .stream_byte (req_byte_reg),
        .status      (parse_status),
        .wr          (parse_wr),
        .fill_req    (fill_req)
    );

    tfd_fill u_fill (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fill_req (fill_req),
        .busy     (fill_busy),
        .wr       (fill_wr)
    );

    tfd_ram #(
        .WIDTH (8),
        .DEPTH (TILE_COUNT)
    ) u_store (
        .clk   (aclk),
        .we    (ram_wr.en),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .re    (s_fire && s_action),
        .raddr (idx_ext[ADDR_W-1:0]),
        .rdata (rdata)
    );

    always_comb begin
        req_valid_next = req_valid_reg;
        m_valid_next   = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (process) begin
            req_valid_next = 1'b0;
            m_valid_next   = 1'b1;
        end
        if (s_fire) begin
            req_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            req_valid_reg <= req_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // The RAM read data holds until the next read, so a stalled read word stays intact.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_action_reg  <= s_action;
            req_byte_reg    <= s_stream_byte;
            req_inrange_reg <= idx_ext < IDX_EXT_W'(TILE_COUNT);
        end
        if (process) begin
            if (req_action_reg) begin
                m_tile_reg   <= req_inrange_reg ? rdata : 8'h00;
                m_status_reg <= ST_PROGRESS;
            end else begin
                m_tile_reg   <= 8'h00;
                m_status_reg <= parse_status;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_tile_value = m_tile_reg;
    assign m_status     = m_status_reg;

    a_single_writer : assert property (@(posedge aclk) disable iff (!aresetn)
        !(fill_busy && parse_wr.en))
        else $error("fill sweep and patch write collide on the tile store");

    a_no_accept_in_fill : assert property (@(posedge aclk) disable iff (!aresetn)
        fill_busy |-> !s_ready)
        else $error("input accepted while the store is being filled");

    a_result_loaded : assert property (@(posedge aclk) disable iff (!aresetn)
        process |=> (m_valid && !req_valid_reg))
        else $error("resolved request did not reach the result register");

    a_fill_after_header : assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_req.start && !fill_busy) |=> fill_busy)
        else $error("fill header did not start the sweep");

endmodule
`default_nettype wire
